@@ design/dlb_pkg.sv @@
// ----------------------------------------------------------------------------
// dlb_pkg: shared types and constants for the desync episode leaky bucket
// Request codes, register indexes, reset values and word layouts.
// ----------------------------------------------------------------------------
package dlb_pkg;

  localparam int unsigned LevelW   = 8;
  localparam int unsigned HoldW    = 16;
  localparam int unsigned CountW   = 8;
  localparam int unsigned ReqW     = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 32;

  typedef enum logic [ReqW-1:0] {
    REQ_TICK    = 2'd0,
    REQ_EPISODE = 2'd1,
    REQ_CLEAR   = 2'd2
  } dlb_req_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CHARGE_JUMP   = 3'd0,
    CFG_CHARGE_STALL  = 3'd1,
    CFG_LATCH_LIMIT   = 3'd2,
    CFG_DRAIN_PERIOD  = 3'd3,
    CFG_BACKOFF_MIN   = 3'd4,
    CFG_BACKOFF_BASE  = 3'd5,
    CFG_BACKOFF_STEP  = 3'd6,
    CFG_BACKOFF_MAX   = 3'd7
  } dlb_cfg_e;

  localparam logic [LevelW-1:0] LevelMax        = 8'd255;
  localparam logic [CountW-1:0] CountMax        = 8'd255;
  localparam logic [7:0]        RstChargeJump   = 8'd8;
  localparam logic [7:0]        RstChargeStall  = 8'd12;
  localparam logic [7:0]        RstLatchLimit   = 8'd40;
  localparam logic [7:0]        RstDrainPeriod  = 8'd100;
  localparam logic [7:0]        RstBackoffMin   = 8'd16;
  localparam logic [15:0]       RstBackoffBase  = 16'd100;
  localparam logic [7:0]        RstBackoffStep  = 8'd25;
  localparam logic [15:0]       RstBackoffMax   = 16'd500;

  typedef struct packed {
    logic [7:0]  charge_jump;
    logic [7:0]  charge_stall;
    logic [7:0]  latch_limit;
    logic [7:0]  drain_period_ms;
    logic [7:0]  backoff_min_level;
    logic [15:0] backoff_base_ms;
    logic [7:0]  backoff_step_ms;
    logic [15:0] backoff_max_ms;
  } dlb_cfg_t;

  typedef struct packed {
    logic              episode_is_jump;
    logic              in_closed_loop;
    logic [CountW-1:0] blind_step_count;
    logic [CountW-1:0] demag_run_count;
  } dlb_in_t;

endpackage

@@ design/desync_episode_leaky_bucket.sv @@
// ----------------------------------------------------------------------------
// desync_episode_leaky_bucket: leaky-bucket guard against desync episodes
// Charges a bucket per episode, arms a level-scaled restart holdoff, drains
// on healthy ticks, flags a fault trip at the latch limit and empties on clear.
// ----------------------------------------------------------------------------
//
//  channel   dir  width  contents
//  s_axis    in   24+2   tdata: episode_is_jump, in_closed_loop, blind, demag
//                        tuser: req_type
//  m_axis    out  32     tdata: bucket_level, holdoff_ms_left, holdoff_active,
//                        fault_trip
//  cfg       in   3+16   index and data, written on cfg_we_i
//
//  One word per cycle sustained while m_axis_tready is high; a word is held
//  in the input register, then the result register. The input register feeds
//  one pass of update logic, whose critical path is the charge add and
//  saturate, the 8x8 holdoff multiply, add and clamp, into the result register.
//  A stalled result holds; the input side keeps accepting while the result
//  register can drain. Reset clears the state and loads register defaults.
//
module desync_episode_leaky_bucket (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dlb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [dlb_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [0] episode_is_jump, [1] in_closed_loop, [9:2] blind_step_count,
  // [17:10] demag_run_count, [23:18] zero
  input  logic [dlb_pkg::InDataW-1:0]   s_axis_tdata,
  // [1:0] req_type
  input  logic [dlb_pkg::ReqW-1:0]      s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] bucket_level, [23:8] holdoff_ms_left, [24] holdoff_active,
  // [25] fault_trip, [31:26] zero
  output logic [dlb_pkg::OutDataW-1:0]  m_axis_tdata
);

  dlb_pkg::dlb_cfg_t cfg_q;

  logic                            in_valid_q;
  logic [dlb_pkg::ReqW-1:0]        req_q;
  dlb_pkg::dlb_in_t                in_q;

  logic [dlb_pkg::LevelW-1:0]      bucket_q, bucket_d;
  logic [dlb_pkg::HoldW-1:0]       holdoff_q, holdoff_d;
  logic [dlb_pkg::CountW-1:0]      drain_q, drain_d;

  logic                            out_valid_q;
  logic [dlb_pkg::LevelW-1:0]      out_bucket_q;
  logic [dlb_pkg::HoldW-1:0]       out_hold_q;
  logic                            out_active_q;
  logic                            out_trip_q;
  logic                            trip_d;

  logic                            out_ready;
  logic                            fire;
  logic                            in_acc;

  logic [dlb_pkg::LevelW:0]        sum;
  logic [dlb_pkg::LevelW-1:0]      ep_level;
  logic [dlb_pkg::LevelW-1:0]      diff;
  logic [dlb_pkg::HoldW-1:0]       prod;
  logic [dlb_pkg::HoldW:0]         hold_raw;
  logic [dlb_pkg::HoldW-1:0]       hold_clamp;
  logic [dlb_pkg::CountW-1:0]      drain_inc;
  logic                            drain_gate;

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && out_ready;
  assign s_axis_tready = !in_valid_q || out_ready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.charge_jump       <= dlb_pkg::RstChargeJump;
      cfg_q.charge_stall      <= dlb_pkg::RstChargeStall;
      cfg_q.latch_limit       <= dlb_pkg::RstLatchLimit;
      cfg_q.drain_period_ms   <= dlb_pkg::RstDrainPeriod;
      cfg_q.backoff_min_level <= dlb_pkg::RstBackoffMin;
      cfg_q.backoff_base_ms   <= dlb_pkg::RstBackoffBase;
      cfg_q.backoff_step_ms   <= dlb_pkg::RstBackoffStep;
      cfg_q.backoff_max_ms    <= dlb_pkg::RstBackoffMax;
    end else if (cfg_we_i) begin
      unique case (dlb_pkg::dlb_cfg_e'(cfg_idx_i))
        dlb_pkg::CFG_CHARGE_JUMP:  cfg_q.charge_jump       <= cfg_wdata_i[7:0];
        dlb_pkg::CFG_CHARGE_STALL: cfg_q.charge_stall      <= cfg_wdata_i[7:0];
        dlb_pkg::CFG_LATCH_LIMIT:  cfg_q.latch_limit       <= cfg_wdata_i[7:0];
        dlb_pkg::CFG_DRAIN_PERIOD: cfg_q.drain_period_ms   <= cfg_wdata_i[7:0];
        dlb_pkg::CFG_BACKOFF_MIN:  cfg_q.backoff_min_level <= cfg_wdata_i[7:0];
        dlb_pkg::CFG_BACKOFF_BASE: cfg_q.backoff_base_ms   <= cfg_wdata_i;
        dlb_pkg::CFG_BACKOFF_STEP: cfg_q.backoff_step_ms   <= cfg_wdata_i[7:0];
        dlb_pkg::CFG_BACKOFF_MAX:  cfg_q.backoff_max_ms    <= cfg_wdata_i;
        default:                   cfg_q                   <= cfg_q;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q                 <= s_axis_tuser;
      in_q.episode_is_jump  <= s_axis_tdata[0];
      in_q.in_closed_loop   <= s_axis_tdata[1];
      in_q.blind_step_count <= s_axis_tdata[9:2];
      in_q.demag_run_count  <= s_axis_tdata[17:10];
    end
  end

  // update pass
  always_comb begin
    sum        = {1'b0, bucket_q} +
                 {1'b0, (in_q.episode_is_jump ? cfg_q.charge_jump : cfg_q.charge_stall)};
    ep_level   = sum[dlb_pkg::LevelW] ? dlb_pkg::LevelMax : sum[dlb_pkg::LevelW-1:0];
    diff       = ep_level - cfg_q.backoff_min_level;
    prod       = {8'd0, diff} * {8'd0, cfg_q.backoff_step_ms};
    hold_raw   = {1'b0, cfg_q.backoff_base_ms} + {1'b0, prod};
    hold_clamp = (hold_raw > {1'b0, cfg_q.backoff_max_ms}) ? cfg_q.backoff_max_ms
                                                          : hold_raw[dlb_pkg::HoldW-1:0];
    drain_inc  = (drain_q == dlb_pkg::CountMax) ? drain_q : drain_q + 1'b1;
    drain_gate = in_q.in_closed_loop && (in_q.blind_step_count == '0) &&
                 (in_q.demag_run_count == '0) && (bucket_q != '0);

    bucket_d  = bucket_q;
    holdoff_d = holdoff_q;
    drain_d   = drain_q;
    trip_d    = 1'b0;

    case (req_q)
      dlb_pkg::REQ_TICK: begin
        if (holdoff_q != '0) begin
          holdoff_d = holdoff_q - 1'b1;
        end
        if (drain_gate) begin
          if (drain_inc >= cfg_q.drain_period_ms) begin
            drain_d  = '0;
            bucket_d = bucket_q - 1'b1;
          end else begin
            drain_d = drain_inc;
          end
        end else begin
          drain_d = '0;
        end
      end
      dlb_pkg::REQ_EPISODE: begin
        bucket_d = ep_level;
        drain_d  = '0;
        if ((ep_level >= cfg_q.backoff_min_level) && (hold_clamp > holdoff_q)) begin
          holdoff_d = hold_clamp;
        end
        trip_d = ep_level >= cfg_q.latch_limit;
      end
      dlb_pkg::REQ_CLEAR: begin
        bucket_d  = '0;
        holdoff_d = '0;
      end
      default: begin
        bucket_d = bucket_q;
      end
    endcase
  end

  // state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_q    <= '0;
      holdoff_q   <= '0;
      drain_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        bucket_q  <= bucket_d;
        holdoff_q <= holdoff_d;
        drain_q   <= drain_d;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_bucket_q <= bucket_d;
      out_hold_q   <= holdoff_d;
      out_active_q <= holdoff_d != '0;
      out_trip_q   <= trip_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_trip_q, out_active_q, out_hold_q, out_bucket_q};

  // checks
  a_stall_only_on_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without a blocked result");

  a_clear_empties : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (req_q == dlb_pkg::REQ_CLEAR)) |=> ((bucket_q == '0) && (holdoff_q == '0)))
    else $error("clear left bucket or holdoff set");

  a_trip_only_episode : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (req_q != dlb_pkg::REQ_EPISODE)) |=> !out_trip_q)
    else $error("fault trip on a non-episode word");

  a_tick_no_rise : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (req_q == dlb_pkg::REQ_TICK)) |=>
      ((bucket_q <= $past(bucket_q)) && (holdoff_q <= $past(holdoff_q))))
    else $error("tick raised bucket or holdoff");

endmodule

@@ dv/desync_episode_leaky_bucket_checker.sv @@
// ----------------------------------------------------------------------------
// desync_episode_leaky_bucket_checker: status predictor and word comparator
// Tracks register writes and accepted events, predicts the bucket level,
// holdoff and trip flag for each event, and checks every status word that
// leaves the block, in order and field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module desync_episode_leaky_bucket_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dlb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [dlb_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  // [0] episode_is_jump, [1] in_closed_loop, [9:2] blind_step_count,
  // [17:10] demag_run_count, [23:18] zero
  input  logic [dlb_pkg::InDataW-1:0]   s_axis_tdata,
  // [1:0] req_type
  input  logic [dlb_pkg::ReqW-1:0]      s_axis_tuser,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] bucket_level, [23:8] holdoff_ms_left, [24] holdoff_active,
  // [25] fault_trip, [31:26] zero
  input  logic [dlb_pkg::OutDataW-1:0]  m_axis_tdata,
  output int unsigned                   mismatch_count_o,
  output int unsigned                   words_pending_o
);

  typedef struct {
    logic [dlb_pkg::LevelW-1:0] level;
    logic [dlb_pkg::HoldW-1:0]  hold;
    logic                       active;
    logic                       trip;
  } guard_status_t;

  dlb_pkg::dlb_cfg_t          regs;
  logic [dlb_pkg::LevelW-1:0] bucket;
  logic [dlb_pkg::HoldW-1:0]  holdoff;
  logic [dlb_pkg::CountW-1:0] drain;
  guard_status_t              status_due[$];
  guard_status_t              status_want;
  guard_status_t              status_next;
  dlb_pkg::dlb_in_t           event_fields;

  task automatic apply_event(input logic [dlb_pkg::ReqW-1:0] req,
                             input dlb_pkg::dlb_in_t ev,
                             output guard_status_t st);
    int unsigned sum;
    int unsigned hold;
    st.trip = 1'b0;
    case (req)
      dlb_pkg::REQ_TICK: begin
        if (holdoff != '0) holdoff = holdoff - 1'b1;
        if (ev.in_closed_loop && ev.blind_step_count == '0 &&
            ev.demag_run_count == '0 && bucket != '0) begin
          if (drain != dlb_pkg::CountMax) drain = drain + 1'b1;
          if (drain >= regs.drain_period_ms) begin
            drain  = '0;
            bucket = bucket - 1'b1;
          end
        end else begin
          drain = '0;
        end
      end
      dlb_pkg::REQ_EPISODE: begin
        sum = 32'(bucket);
        sum += ev.episode_is_jump ? regs.charge_jump : regs.charge_stall;
        bucket = (sum > dlb_pkg::LevelMax) ? dlb_pkg::LevelMax : sum[dlb_pkg::LevelW-1:0];
        drain  = '0;
        if (bucket >= regs.backoff_min_level) begin
          hold = 32'(bucket);
          hold = regs.backoff_base_ms + (hold - regs.backoff_min_level) * regs.backoff_step_ms;
          if (hold > regs.backoff_max_ms) hold = regs.backoff_max_ms;
          if (hold > holdoff) holdoff = hold[dlb_pkg::HoldW-1:0];
        end
        st.trip = (bucket >= regs.latch_limit);
      end
      dlb_pkg::REQ_CLEAR: begin
        bucket  = '0;
        holdoff = '0;
      end
      default: ;
    endcase
    st.level  = bucket;
    st.hold   = holdoff;
    st.active = (holdoff != '0);
  endtask

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatch_count_o++;
      $display("%0t ns %s: expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs.charge_jump       = dlb_pkg::RstChargeJump;
      regs.charge_stall      = dlb_pkg::RstChargeStall;
      regs.latch_limit       = dlb_pkg::RstLatchLimit;
      regs.drain_period_ms   = dlb_pkg::RstDrainPeriod;
      regs.backoff_min_level = dlb_pkg::RstBackoffMin;
      regs.backoff_base_ms   = dlb_pkg::RstBackoffBase;
      regs.backoff_step_ms   = dlb_pkg::RstBackoffStep;
      regs.backoff_max_ms    = dlb_pkg::RstBackoffMax;
      bucket           = '0;
      holdoff          = '0;
      drain            = '0;
      status_due.delete();
      mismatch_count_o = 0;
      words_pending_o  = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (status_due.size() == 0) begin
          mismatch_count_o++;
          $display("%0t ns unexpected word: expected none, actual %h", $time, m_axis_tdata);
        end else begin
          status_want = status_due.pop_front();
          check_field("bucket_level", status_want.level, m_axis_tdata[7:0]);
          check_field("holdoff_ms_left", status_want.hold, m_axis_tdata[23:8]);
          check_field("holdoff_active", status_want.active, m_axis_tdata[24]);
          check_field("fault_trip", status_want.trip, m_axis_tdata[25]);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          dlb_pkg::CFG_CHARGE_JUMP:  regs.charge_jump       = cfg_wdata_i[7:0];
          dlb_pkg::CFG_CHARGE_STALL: regs.charge_stall      = cfg_wdata_i[7:0];
          dlb_pkg::CFG_LATCH_LIMIT:  regs.latch_limit       = cfg_wdata_i[7:0];
          dlb_pkg::CFG_DRAIN_PERIOD: regs.drain_period_ms   = cfg_wdata_i[7:0];
          dlb_pkg::CFG_BACKOFF_MIN:  regs.backoff_min_level = cfg_wdata_i[7:0];
          dlb_pkg::CFG_BACKOFF_BASE: regs.backoff_base_ms   = cfg_wdata_i;
          dlb_pkg::CFG_BACKOFF_STEP: regs.backoff_step_ms   = cfg_wdata_i[7:0];
          dlb_pkg::CFG_BACKOFF_MAX:  regs.backoff_max_ms    = cfg_wdata_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        event_fields.episode_is_jump  = s_axis_tdata[0];
        event_fields.in_closed_loop   = s_axis_tdata[1];
        event_fields.blind_step_count = s_axis_tdata[9:2];
        event_fields.demag_run_count  = s_axis_tdata[17:10];
        apply_event(s_axis_tuser, event_fields, status_next);
        status_due.push_back(status_next);
      end
      words_pending_o = status_due.size();
    end
  end

endmodule

@@ dv/desync_episode_leaky_bucket_test.sv @@
// ----------------------------------------------------------------------------
// desync_episode_leaky_bucket_test: top-level testbench for the leaky bucket
// Drives directed and random tick, episode, clear and unused events under
// several register settings and idling mixes; the checker beside the block
// predicts and compares every status word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module desync_episode_leaky_bucket_test;

  localparam logic [dlb_pkg::ReqW-1:0] ReqUnused = 2'd3;
  localparam int unsigned     NumStages = 8;
  localparam int unsigned     StageWords = 50;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [dlb_pkg::CfgIdxW-1:0]   cfg_idx_i;
  logic [dlb_pkg::CfgDataW-1:0]  cfg_wdata_i;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [dlb_pkg::InDataW-1:0]   s_axis_tdata;
  logic [dlb_pkg::ReqW-1:0]      s_axis_tuser;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [dlb_pkg::OutDataW-1:0]  m_axis_tdata;
  int unsigned                   mismatch_count;
  int unsigned                   words_pending;
  int unsigned                   tx_idle_pct;
  int unsigned                   rx_stall_pct;

  desync_episode_leaky_bucket DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  desync_episode_leaky_bucket_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .mismatch_count_o (mismatch_count),
    .words_pending_o  (words_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("[desync_episode_leaky_bucket] ERROR");
    $finish;
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready = ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic send_event(input logic [dlb_pkg::ReqW-1:0] req, input logic jump,
                            input logic closed, input logic [7:0] blind,
                            input logic [7:0] demag);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid = 1'b0;
      s_axis_tdata  = {6'b0, 18'($urandom)};
      s_axis_tuser  = 2'($urandom);
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = req;
    s_axis_tdata  = {6'b0, demag, blind, closed, jump};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic send_random_event();
    int unsigned                pick;
    logic [dlb_pkg::ReqW-1:0]   req;
    logic                       jump;
    logic                       closed;
    logic [7:0]                 blind;
    logic [7:0]                 demag;
    pick   = $urandom_range(99);
    jump   = 1'($urandom);
    closed = 1'($urandom);
    blind  = 8'($urandom);
    demag  = 8'($urandom);
    if (pick < 55) begin
      req = dlb_pkg::REQ_TICK;
      if ($urandom_range(99) < 75) begin
        closed = 1'b1;
        blind  = '0;
        demag  = '0;
      end else begin
        case ($urandom_range(2))
          0: blind = '0;
          1: demag = '0;
          default: ;
        endcase
      end
    end else if (pick < 85) begin
      req = dlb_pkg::REQ_EPISODE;
    end else if (pick < 93) begin
      req = dlb_pkg::REQ_CLEAR;
    end else begin
      req = ReqUnused;
    end
    send_event(req, jump, closed, blind, demag);
  endtask

  task automatic settle();
    wait (words_pending == 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input dlb_pkg::dlb_cfg_e idx,
                           input logic [dlb_pkg::CfgDataW-1:0] val);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // upper bits of the 8-bit registers carry noise and must be dropped
  task automatic load_settings(input logic [7:0] cj, input logic [7:0] cs,
                               input logic [7:0] ll, input logic [7:0] dp,
                               input logic [7:0] bm, input logic [15:0] bb,
                               input logic [7:0] bs, input logic [15:0] bx);
    logic [7:0] noise;
    noise = 8'($urandom);
    settle();
    write_reg(dlb_pkg::CFG_CHARGE_JUMP, {noise, cj});
    write_reg(dlb_pkg::CFG_CHARGE_STALL, {noise, cs});
    write_reg(dlb_pkg::CFG_LATCH_LIMIT, {noise, ll});
    write_reg(dlb_pkg::CFG_DRAIN_PERIOD, {noise, dp});
    write_reg(dlb_pkg::CFG_BACKOFF_MIN, {noise, bm});
    write_reg(dlb_pkg::CFG_BACKOFF_BASE, bb);
    write_reg(dlb_pkg::CFG_BACKOFF_STEP, {noise, bs});
    write_reg(dlb_pkg::CFG_BACKOFF_MAX, bx);
  endtask

  function automatic logic [15:0] pick_value(input int unsigned narrow_hi,
                                             input int unsigned full_hi);
    if ($urandom_range(3) == 0) return 16'($urandom_range(full_hi));
    return 16'($urandom_range(narrow_hi));
  endfunction

  initial begin
    int unsigned stage;
    int unsigned n;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    tx_idle_pct   = 0;
    rx_stall_pct  = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_event(ReqUnused, 1'b1, 1'b1, 8'd0, 8'd0);
    send_event(dlb_pkg::REQ_TICK, 1'b0, 1'b1, 8'd0, 8'd0);
    send_event(dlb_pkg::REQ_EPISODE, 1'b0, 1'b0, 8'd255, 8'd255);
    send_event(dlb_pkg::REQ_EPISODE, 1'b0, 1'b1, 8'd0, 8'd0);
    send_event(dlb_pkg::REQ_EPISODE, 1'b1, 1'b0, 8'd170, 8'd85);
    send_event(dlb_pkg::REQ_EPISODE, 1'b1, 1'b1, 8'd85, 8'd170);
    send_event(dlb_pkg::REQ_TICK, 1'b0, 1'b1, 8'd255, 8'd0);
    send_event(dlb_pkg::REQ_TICK, 1'b0, 1'b1, 8'd0, 8'd255);
    send_event(dlb_pkg::REQ_TICK, 1'b1, 1'b0, 8'd0, 8'd0);
    send_event(dlb_pkg::REQ_TICK, 1'b0, 1'b1, 8'd0, 8'd0);
    send_event(ReqUnused, 1'b0, 1'b0, 8'd255, 8'd255);
    send_event(dlb_pkg::REQ_CLEAR, 1'b1, 1'b1, 8'd0, 8'd0);
    send_event(dlb_pkg::REQ_TICK, 1'b0, 1'b1, 8'd0, 8'd0);

    load_settings(8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 16'hFFFF, 8'd255, 16'hFFFF);
    send_event(dlb_pkg::REQ_EPISODE, 1'b0, 1'b0, 8'd0, 8'd0);
    send_event(dlb_pkg::REQ_EPISODE, 1'b1, 1'b0, 8'd0, 8'd0);
    send_event(dlb_pkg::REQ_EPISODE, 1'b1, 1'b1, 8'd0, 8'd0);
    send_event(dlb_pkg::REQ_TICK, 1'b0, 1'b1, 8'd0, 8'd0);
    send_event(dlb_pkg::REQ_TICK, 1'b0, 1'b1, 8'd0, 8'd0);
    send_event(dlb_pkg::REQ_TICK, 1'b0, 1'b1, 8'd1, 8'd0);
    send_event(dlb_pkg::REQ_CLEAR, 1'b0, 1'b0, 8'd0, 8'd0);

    for (stage = 0; stage < NumStages; stage++) begin
      case (stage)
        0: load_settings(dlb_pkg::RstChargeJump, dlb_pkg::RstChargeStall,
                         dlb_pkg::RstLatchLimit, dlb_pkg::RstDrainPeriod,
                         dlb_pkg::RstBackoffMin, dlb_pkg::RstBackoffBase,
                         dlb_pkg::RstBackoffStep, dlb_pkg::RstBackoffMax);
        3: load_settings('0, '0, '0, '0, '0, '0, '0, '0);
        7: load_settings(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 16'hFFFF, 8'd255,
                         16'hFFFF);
        default: load_settings(8'(pick_value(20, 255)), 8'(pick_value(20, 255)),
                               8'(pick_value(80, 255)), 8'(pick_value(6, 255)),
                               8'(pick_value(40, 255)), pick_value(30, 65535),
                               8'(pick_value(10, 255)), pick_value(60, 65535));
      endcase
      case (stage % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 68; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 68; end
        default: begin tx_idle_pct = 33; rx_stall_pct = 33; end
      endcase
      for (n = 0; n < StageWords; n++) begin
        if (stage == 2 && n == StageWords / 2) begin
          s_axis_tvalid = 1'b0;
          settle();
        end
        send_random_event();
      end
      s_axis_tvalid = 1'b0;
    end

    wait (words_pending == 0);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[desync_episode_leaky_bucket] OK");
    end else begin
      $display("[desync_episode_leaky_bucket] ERROR");
    end
    $finish;
  end

endmodule
